// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define LRM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next one.
`define LRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lrm_pkg.sv
package lrm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_VOL,
        ST_ACC,
        ST_FIN,
        ST_OUT
    } lrm_state_t;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_MIX   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CHANNELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME          = 3'd4;

    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;

    localparam logic [15:0] VOL_UNITY   = 16'd32768;
    localparam logic [18:0] RATIO_RESET = 19'd65536;

    localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
    localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 32;

endpackage

// File: design/lrm_frame_ram.sv
module lrm_frame_ram
    import lrm_pkg::*;
#(
    parameter int DEPTH = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr0,
    input  logic [ADDR_W-1:0]  rd_addr1,
    output logic [FRAME_W-1:0] rd_data0,
    output logic [FRAME_W-1:0] rd_data1
);

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] rd0_reg;
    logic [FRAME_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

// File: design/linear_resample_mixer.sv
// Linear-interpolating resampler and mixer. Source frames are pushed into a
// ring of SOURCE_FRAMES stereo frames held in one frame RAM with two read
// ports; a mix item interpolates between the frames at the read point and the
// next one at a FRACTION_BITS fractional position, remaps channels, applies
// volume, adds the given output frame with 16-bit saturation and advances the
// position by rate_ratio. One item is processed at a time. Push, flush, the
// unused code, disabled mix and underrun go from acceptance straight to the
// output step; an active mix first walks the interpolation multiply, channel
// sum, volume multiply, accumulate and finalize steps of the sequencer. Each
// result is held in pending registers and loaded into the output register
// once that register is free or being taken, so a stalled output delays it. A new
// item is accepted while the previous result waits in the output register. The
// frame RAM needs no clearing after reset.
`include "assert_macros.svh"

module linear_resample_mixer
    import lrm_pkg::*;
#(
    parameter int SOURCE_FRAMES = 8192,
    parameter int FRACTION_BITS = 16,
    localparam int CW = $clog2(SOURCE_FRAMES + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic signed [SAMPLE_W-1:0]  s_src_left,
    input  logic signed [SAMPLE_W-1:0]  s_src_right,
    input  logic signed [SAMPLE_W-1:0]  s_dst_left,
    input  logic signed [SAMPLE_W-1:0]  s_dst_right,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_out_left,
    output logic signed [SAMPLE_W-1:0]  m_out_right,
    output logic                        m_underrun,
    output logic                        m_overflow,
    output logic [CW-1:0]               m_frames_held
);

    localparam int AW  = $clog2(SOURCE_FRAMES);
    localparam int F   = FRACTION_BITS;
    localparam int IW  = F + 18;
    localparam int PLW = F + 16;
    localparam int PTW = F + 35;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [18:0] r;
        if (v > SAMPLE_MAX) begin
            r = SAMPLE_MAX;
        end else if (v < SAMPLE_MIN) begin
            r = SAMPLE_MIN;
        end else begin
            r = v;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // control state
    lrm_state_t          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [F-1:0]        frac_reg, frac_next;
    logic                m_valid_reg, m_valid_next;

    logic                run_en_reg;
    logic [1:0]          src_ch_reg;
    logic [1:0]          out_ch_reg;
    logic [18:0]         ratio_reg;
    logic [15:0]         vol_reg;

    // payload
    logic signed [15:0]  dst_l_reg, dst_r_reg;
    logic signed [15:0]  a_l_reg, a_r_reg;
    logic signed [IW-1:0] prod_l_reg, prod_r_reg;
    logic signed [IW-1:0] nl_reg, nr_reg;
    logic                half_reg;
    logic signed [34:0]  phi_l_reg, phi_r_reg;
    logic [PLW-1:0]      plo_l_reg, plo_r_reg;
    logic signed [PTW-1:0] p_l_reg, p_r_reg;

    logic signed [15:0]  pend_l_reg, pend_l_next;
    logic signed [15:0]  pend_r_reg, pend_r_next;
    logic                pend_und_reg, pend_und_next;
    logic                pend_ovf_reg, pend_ovf_next;

    logic signed [15:0]  m_left_reg, m_right_reg;
    logic                m_und_reg, m_ovf_reg;
    logic [CW-1:0]       m_held_reg;

    // frame RAM
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr1;
    logic [FRAME_W-1:0]  rd_data0, rd_data1;

    logic                accept;
    logic                out_load;
    logic [CW:0]         slot_sum;
    logic [AW:0]         next_sum;

    lrm_frame_ram #(
        .DEPTH    (SOURCE_FRAMES)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  ({s_src_right, s_src_left}),
        .rd_addr0 (rd_idx_reg),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign slot_sum = (CW + 1)'(rd_idx_reg) + (CW + 1)'(count_reg);
    assign wr_addr  = (slot_sum >= (CW + 1)'(SOURCE_FRAMES))
                    ? AW'(slot_sum - (CW + 1)'(SOURCE_FRAMES)) : AW'(slot_sum);
    assign next_sum = (AW + 1)'(rd_idx_reg) + (AW + 1)'(1);
    assign rd_addr1 = (next_sum >= (AW + 1)'(SOURCE_FRAMES))
                    ? AW'(next_sum - (AW + 1)'(SOURCE_FRAMES)) : AW'(next_sum);
    assign wr_en    = accept && (s_func == FUNC_PUSH) && (count_reg < CW'(SOURCE_FRAMES));

    // interpolation multiply
    logic signed [16:0]  diff_l, diff_r;
    logic signed [F:0]   frac_s;
    logic signed [IW-1:0] prod_l, prod_r;

    assign diff_l = 17'(signed'(rd_data1[15:0])) - 17'(signed'(rd_data0[15:0]));
    assign diff_r = 17'(signed'(rd_data1[31:16])) - 17'(signed'(rd_data0[31:16]));
    assign frac_s = signed'({1'b0, frac_reg});
    assign prod_l = diff_l * frac_s;
    assign prod_r = diff_r * frac_s;

    // interpolated sums and channel remap
    logic signed [IW-1:0] s_l, s_r, nl, nr;
    logic                 ch_ok;

    assign s_l   = (IW'(a_l_reg) <<< F) + prod_l_reg;
    assign s_r   = (IW'(a_r_reg) <<< F) + prod_r_reg;
    assign ch_ok = (src_ch_reg == CH_MONO || src_ch_reg == CH_STEREO) &&
                   (out_ch_reg == CH_MONO || out_ch_reg == CH_STEREO);

    always_comb begin
        nl = '0;
        nr = '0;
        if (ch_ok) begin
            if (src_ch_reg == CH_MONO) begin
                nl = s_l;
                nr = s_l;
            end else if (out_ch_reg == CH_STEREO) begin
                nl = s_l;
                nr = s_r;
            end else begin
                nl = s_l + s_r;
            end
        end
    end

    // volume multiply, split in integer and fraction parts
    logic [15:0]         vol_sat;
    logic signed [34:0]  phi_l, phi_r;
    logic [PLW-1:0]      plo_l, plo_r;

    assign vol_sat = (vol_reg > VOL_UNITY) ? VOL_UNITY : vol_reg;
    assign phi_l = signed'(nl_reg[IW-1:F]) * signed'({1'b0, vol_sat});
    assign phi_r = signed'(nr_reg[IW-1:F]) * signed'({1'b0, vol_sat});
    assign plo_l = nl_reg[F-1:0] * vol_sat;
    assign plo_r = nr_reg[F-1:0] * vol_sat;

    logic signed [PTW-1:0] p_l, p_r;

    assign p_l = (PTW'(phi_l_reg) <<< F) + signed'(PTW'(plo_l_reg));
    assign p_r = (PTW'(phi_r_reg) <<< F) + signed'(PTW'(plo_r_reg));

    // scale down, truncate toward zero, add and saturate
    logic signed [PTW-1:0] pf_l, pf_r;
    logic                  rnd_l, rnd_r;
    logic signed [17:0]    q_l, q_r;
    logic signed [SAMPLE_W-1:0] mix_l, mix_r;

    always_comb begin
        if (half_reg) begin
            pf_l  = p_l_reg >>> (F + 16);
            pf_r  = p_r_reg >>> (F + 16);
            rnd_l = p_l_reg[PTW-1] && (p_l_reg[F+15:0] != '0);
            rnd_r = p_r_reg[PTW-1] && (p_r_reg[F+15:0] != '0);
        end else begin
            pf_l  = p_l_reg >>> (F + 15);
            pf_r  = p_r_reg >>> (F + 15);
            rnd_l = p_l_reg[PTW-1] && (p_l_reg[F+14:0] != '0);
            rnd_r = p_r_reg[PTW-1] && (p_r_reg[F+14:0] != '0);
        end
        q_l   = pf_l[17:0] + 18'(rnd_l);
        q_r   = pf_r[17:0] + 18'(rnd_r);
        mix_l = sat16(19'(dst_l_reg) + 19'(q_l));
        mix_r = sat16(19'(dst_r_reg) + 19'(q_r));
    end

    // position advance
    logic [F+18:0] ratio_sh;
    logic [F+2:0]  step;
    logic [F+3:0]  pos;
    logic [3:0]    whole;
    logic [AW:0]   idx_sum;

    assign ratio_sh = {ratio_reg, {F{1'b0}}};
    assign step     = ratio_sh[F+18:16];
    assign pos      = (F + 4)'(frac_reg) + (F + 4)'(step);
    assign whole    = pos[F+3:F];
    assign idx_sum  = (AW + 1)'(rd_idx_reg) + (AW + 1)'(whole);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        frac_next     = frac_reg;
        pend_l_next   = pend_l_reg;
        pend_r_next   = pend_r_reg;
        pend_und_next = pend_und_reg;
        pend_ovf_next = pend_ovf_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_l_next   = '0;
                    pend_r_next   = '0;
                    pend_und_next = 1'b0;
                    pend_ovf_next = 1'b0;
                    state_next    = ST_OUT;
                    case (s_func)
                        FUNC_PUSH: begin
                            if (count_reg >= CW'(SOURCE_FRAMES)) begin
                                pend_ovf_next = 1'b1;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_MIX: begin
                            pend_l_next = s_dst_left;
                            pend_r_next = (out_ch_reg == CH_STEREO) ? s_dst_right : '0;
                            if (run_en_reg) begin
                                if (count_reg < CW'(2)) begin
                                    pend_und_next = 1'b1;
                                end else begin
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        FUNC_FLUSH: begin
                            count_next  = '0;
                            rd_idx_next = '0;
                            frac_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: state_next = ST_SUM;
            ST_SUM: state_next = ST_VOL;
            ST_VOL: state_next = ST_ACC;
            ST_ACC: state_next = ST_FIN;
            ST_FIN: begin
                pend_l_next = mix_l;
                if (out_ch_reg == CH_STEREO) begin
                    pend_r_next = mix_r;
                end
                if (32'(whole) >= 32'(count_reg)) begin
                    count_next  = '0;
                    rd_idx_next = '0;
                    frac_next   = '0;
                end else begin
                    count_next  = count_reg - CW'(whole);
                    frac_next   = pos[F-1:0];
                    rd_idx_next = (idx_sum >= (AW + 1)'(SOURCE_FRAMES))
                                ? AW'(idx_sum - (AW + 1)'(SOURCE_FRAMES)) : AW'(idx_sum);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            frac_reg    <= '0;
            m_valid_reg <= 1'b0;
            run_en_reg  <= 1'b0;
            src_ch_reg  <= CH_STEREO;
            out_ch_reg  <= CH_STEREO;
            ratio_reg   <= RATIO_RESET;
            vol_reg     <= VOL_UNITY;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            frac_reg    <= frac_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_RUN_ENABLE:      run_en_reg <= cfg_data[0];
                    CFG_SOURCE_CHANNELS: src_ch_reg <= cfg_data[1:0];
                    CFG_OUTPUT_CHANNELS: out_ch_reg <= cfg_data[1:0];
                    CFG_RATE_RATIO:      ratio_reg  <= cfg_data[18:0];
                    CFG_VOLUME:          vol_reg    <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_l_reg   <= pend_l_next;
        pend_r_reg   <= pend_r_next;
        pend_und_reg <= pend_und_next;
        pend_ovf_reg <= pend_ovf_next;
        if (accept) begin
            dst_l_reg <= s_dst_left;
            dst_r_reg <= s_dst_right;
        end
        if (state_reg == ST_MUL) begin
            a_l_reg    <= signed'(rd_data0[15:0]);
            a_r_reg    <= signed'(rd_data0[31:16]);
            prod_l_reg <= prod_l;
            prod_r_reg <= prod_r;
        end
        if (state_reg == ST_SUM) begin
            nl_reg   <= nl;
            nr_reg   <= nr;
            half_reg <= ch_ok && (src_ch_reg == CH_STEREO) && (out_ch_reg == CH_MONO);
        end
        if (state_reg == ST_VOL) begin
            phi_l_reg <= phi_l;
            phi_r_reg <= phi_r;
            plo_l_reg <= plo_l;
            plo_r_reg <= plo_r;
        end
        if (state_reg == ST_ACC) begin
            p_l_reg <= p_l;
            p_r_reg <= p_r;
        end
        if (out_load) begin
            m_left_reg  <= pend_l_reg;
            m_right_reg <= pend_r_reg;
            m_und_reg   <= pend_und_reg;
            m_ovf_reg   <= pend_ovf_reg;
            m_held_reg  <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_left    = m_left_reg;
    assign m_out_right   = m_right_reg;
    assign m_underrun    = m_und_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_frames_held = m_held_reg;

    `LRM_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(SOURCE_FRAMES), "frame count beyond ring depth")
    `LRM_ASSERT(a_index_bound, aclk, aresetn, 32'(rd_idx_reg) < 32'(SOURCE_FRAMES), "read index beyond ring depth")
    `LRM_ASSERT_NEXT(a_pos_hold, aclk, aresetn, state_reg == ST_MUL || state_reg == ST_SUM || state_reg == ST_VOL || state_reg == ST_ACC, $stable(frac_reg) && $stable(count_reg), "position moved before finalize")
    `LRM_ASSERT_NEXT(a_full_drop, aclk, aresetn, accept && s_func == FUNC_PUSH && count_reg == CW'(SOURCE_FRAMES), $stable(count_reg) && pend_ovf_reg, "push into full ring not dropped")

endmodule
